// ----- design/led_matrix_pwm_refresh_macros.svh -----
// Assertion macros shared by the LED matrix refresh design.
`ifndef LED_MATRIX_PWM_REFRESH_MACROS_SVH
`define LED_MATRIX_PWM_REFRESH_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LMPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LMPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/lmpr_pkg.sv -----
// Package with the constants, types and gamma table of the LED matrix refresh engine.
`default_nettype none

package lmpr_pkg;

   localparam int ROWS      = 8;
   localparam int COLS      = 8;
   localparam int SLICES    = 32;
   localparam int BLANKS    = 3;
   localparam int ROW_WORDS = SLICES + BLANKS;
   localparam int GAMMA_MAX = 31;

   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ROW_DW = COLS * 8;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   localparam logic [4:0] GAMMA_TABLE [32] = '{
      5'd0,  5'd1,  5'd1,  5'd1,  5'd1,  5'd2,  5'd2,  5'd3,
      5'd3,  5'd4,  5'd5,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,
      5'd10, 5'd11, 5'd12, 5'd13, 5'd15, 5'd16, 5'd17, 5'd19,
      5'd20, 5'd22, 5'd23, 5'd25, 5'd26, 5'd28, 5'd30, 5'd31
   };

   // Brightness above the table range lights as the brightest entry.
   function automatic logic [4:0] gamma_level(input logic [7:0] value);
      logic [4:0] idx;
      if (value > 8'(GAMMA_MAX)) begin
         idx = 5'(GAMMA_MAX);
      end else begin
         idx = value[4:0];
      end
      return GAMMA_TABLE[idx];
   endfunction

endpackage

`default_nettype wire

// ----- design/lmpr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module lmpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/led_matrix_pwm_refresh.sv -----
// Top level of the refresh engine for a row-multiplexed LED matrix.
// A request carries a mode: write stores one pixel brightness, read returns one,
// and tick returns the next refresh word (row one-hot in the low byte, column
// mask in the high byte, all zero during the blank words after each row).
// Requests enter on req_valid/req_stall and results leave on rsp_valid/rsp_stall;
// writes and unused modes give no result.
// Pixels live in a row-wide memory, one 64-bit word per row. A request is taken
// only when no other is in work: the row is read on the accepting edge, and in
// ST_EXEC it is merged and written back or loaded into the result register,
// which drives rsp_valid. No new request is taken until ST_EXEC is left.
// While the result register holds a stalled result, the block still accepts a
// request, but a read or tick then waits until the register frees.
// Reset clears the scan position and a valid bit per row, so every pixel reads
// as zero at once; no clearing pass is needed.
`default_nettype none
`include "led_matrix_pwm_refresh_macros.svh"

module led_matrix_pwm_refresh (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [2:0]  req_column,
   input  wire logic [2:0]  req_row,
   input  wire logic [7:0]  req_pixel_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [15:0] rsp_refresh_word,
   output      logic        rsp_frame_end,
   output      logic [7:0]  rsp_read_value,
   output      logic        rsp_is_read
);

   import lmpr_pkg::*;

   state_type         state_ff, state_in;
   logic [1:0]        mode_ff;
   logic [COL_AW-1:0] col_ff;
   logic [ROW_AW-1:0] addr_ff;
   logic [7:0]        value_ff;
   logic              in_range_ff;

   logic [ROW_AW-1:0] scan_row_ff, scan_row_in;
   logic [5:0]        slice_ff, slice_in;
   logic [ROWS-1:0]   row_valid_ff, row_valid_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_word_ff;
   logic              rsp_fend_ff;
   logic [7:0]        rsp_read_ff;
   logic              rsp_is_read_ff;

   logic              req_fire;
   logic              load_rsp;
   logic              ram_we;
   logic [ROW_DW-1:0] ram_rd_data;
   logic [COLS-1:0][7:0] cur_row;
   logic [COLS-1:0][7:0] new_row;
   logic [7:0]        col_mask;
   logic [7:0]        row_onehot;
   logic [15:0]       word_in;
   logic              fend_in;
   logic [7:0]        read_in;
   logic              req_in_range;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_fire     = req_valid && !req_stall;
   assign req_in_range = (int'(req_column) < COLS) && (int'(req_row) < ROWS);

   lmpr_ram #(
      .WIDTH (ROW_DW),
      .DEPTH (ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (new_row),
      .rd_en   (req_fire),
      .rd_addr ((req_mode == MODE_TICK) ? scan_row_ff : req_row[ROW_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // A row never written since reset reads as all zero.
   always_comb begin
      cur_row = row_valid_ff[addr_ff] ? ram_rd_data : '0;
      new_row = cur_row;
      new_row[col_ff] = value_ff;
   end

   always_comb begin
      col_mask = '0;
      for (int c = 0; c < COLS; c++) begin
         col_mask[c] = ({1'b0, gamma_level(cur_row[c])} > slice_ff);
      end
      row_onehot = 8'(8'd1 << scan_row_ff);
      word_in    = (int'(slice_ff) < SLICES) ? {col_mask, row_onehot} : 16'd0;
      fend_in    = (int'(scan_row_ff) == ROWS - 1) && (slice_ff == 6'(ROW_WORDS - 1));
      read_in    = in_range_ff ? cur_row[col_ff] : 8'd0;
   end

   always_comb begin
      state_in     = state_ff;
      load_rsp     = 1'b0;
      ram_we       = 1'b0;
      scan_row_in  = scan_row_ff;
      slice_in     = slice_ff;
      row_valid_in = row_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (mode_ff)
               MODE_WRITE: begin
                  ram_we   = in_range_ff;
                  state_in = ST_IDLE;
                  if (in_range_ff) begin
                     row_valid_in[addr_ff] = 1'b1;
                  end
               end
               MODE_TICK, MODE_READ: begin
                  if (!rsp_valid_ff || !rsp_stall) begin
                     load_rsp = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
            if (load_rsp && (mode_ff == MODE_TICK)) begin
               if (slice_ff == 6'(ROW_WORDS - 1)) begin
                  slice_in = '0;
                  if (int'(scan_row_ff) == ROWS - 1) begin
                     scan_row_in = '0;
                  end else begin
                     scan_row_in = scan_row_ff + 1'b1;
                  end
               end else begin
                  slice_in = slice_ff + 6'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_row_ff  <= '0;
         slice_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_row_ff  <= scan_row_in;
         slice_ff     <= slice_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff     <= req_mode;
         col_ff      <= req_column[COL_AW-1:0];
         addr_ff     <= (req_mode == MODE_TICK) ? scan_row_ff : req_row[ROW_AW-1:0];
         value_ff    <= req_pixel_value;
         in_range_ff <= req_in_range;
      end
      if (load_rsp) begin
         if (mode_ff == MODE_TICK) begin
            rsp_word_ff    <= word_in;
            rsp_fend_ff    <= fend_in;
            rsp_read_ff    <= 8'd0;
            rsp_is_read_ff <= 1'b0;
         end else begin
            rsp_word_ff    <= 16'd0;
            rsp_fend_ff    <= 1'b0;
            rsp_read_ff    <= read_in;
            rsp_is_read_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_refresh_word = rsp_word_ff;
   assign rsp_frame_end    = rsp_fend_ff;
   assign rsp_read_value   = rsp_read_ff;
   assign rsp_is_read      = rsp_is_read_ff;

   `LMPR_ASSERT_SAME(a_slice_range, clock, reset, 1'b1, slice_ff < 6'(ROW_WORDS),
      "slice out of range")
   `LMPR_ASSERT_NEXT(a_frame_wrap, clock, reset,
      load_rsp && (mode_ff == MODE_TICK) && fend_in,
      (scan_row_ff == '0) && (slice_ff == '0), "scan did not wrap at frame end")
   `LMPR_ASSERT_NEXT(a_write_silent, clock, reset,
      (state_ff == ST_EXEC) && (mode_ff == MODE_WRITE), !$rose(rsp_valid_ff),
      "write produced a result")
   `LMPR_ASSERT_SAME(a_we_in_exec, clock, reset, ram_we,
      (state_ff == ST_EXEC) && (mode_ff == MODE_WRITE), "row write outside write-back")

endmodule

`default_nettype wire
